FILE: hdl/dbk_pkg.sv
// Shared constants and types for the multi-key debounce block.
// No dependencies.
`default_nettype none
package dbk_pkg;
  localparam int NUM_KEYS     = 13;
  localparam int KEY_W        = 4;
  localparam int FILTER_W     = 8;
  localparam int LEVELS_W     = 13;
  localparam logic [FILTER_W-1:0] FILTER_RESET = FILTER_W'(10);

  typedef logic [NUM_KEYS-1:0] key_mask_t;

  // per-tick findings: lane state changes and released (low) key levels
  typedef struct packed {
    key_mask_t change;
    key_mask_t up;
  } event_set_t;
endpackage
`default_nettype wire

FILE: hdl/dbk_if.sv
// Handshake channel interfaces: key levels in, key events out, filter setting.
// Depends on dbk_pkg.
`default_nettype none
interface dbk_key_if import dbk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] key_levels;
  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface dbk_evt_if import dbk_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;
  logic             is_release;
  logic             last_event;
  modport source (output valid, output key_index, output is_release, output last_event,
                  input ready);
  modport sink   (input valid, input key_index, input is_release, input last_event,
                  output ready);
endinterface

interface dbk_cfg_if import dbk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FILTER_W-1:0] filter_ticks;
  modport source (output valid, output filter_ticks, input ready);
  modport sink   (input valid, input filter_ticks, output ready);
endinterface
`default_nettype wire

FILE: hdl/dbk_lane.sv
// One key lane: tick counter and debounced state, flags a state change.
// Depends on dbk_pkg.
`default_nettype none
module dbk_lane import dbk_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                tick,
  input  wire logic                level,
  input  wire logic [FILTER_W-1:0] filter,
  output logic                     change
);
  logic [FILTER_W-1:0] cnt;
  logic                state;
  logic                expired;

  assign expired = !(cnt < filter);
  assign change  = expired && (level != state);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      state <= 1'b0;
    end else if (tick) begin
      if (expired) begin
        cnt <= '0;
        if (change) begin
          state <= level;
        end
      end else begin
        cnt <= cnt + FILTER_W'(1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/dbk_merge.sv
// Merging stage: holds one tick's changes and sends them lowest key first.
// Depends on dbk_pkg and dbk_if.
`default_nettype none
module dbk_merge import dbk_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  event_set_t      found,
  output logic            idle,
  dbk_evt_if.source       events
);
  key_mask_t        pend;
  key_mask_t        up;
  key_mask_t        sel_bit;
  key_mask_t        rest;
  logic [KEY_W-1:0] sel_idx;
  logic             take;
  logic             o_valid;
  logic [KEY_W-1:0] o_idx;
  logic             o_rel;
  logic             o_last;

  assign idle    = (pend == '0);
  assign take    = !o_valid || events.ready;
  assign sel_bit = pend & (~pend + key_mask_t'(1));
  assign rest    = pend & ~sel_bit;

  always_comb begin
    sel_idx = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (pend[k]) begin
        sel_idx = KEY_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= '0;
      o_valid <= 1'b0;
    end else begin
      if (load) begin
        pend <= found.change;
      end else if (take && !idle) begin
        pend <= rest;
      end
      if (take) begin
        o_valid <= !idle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      up <= found.up;
    end
    if (take && !idle) begin
      o_idx  <= sel_idx;
      o_rel  <= |(up & sel_bit);
      o_last <= (rest == '0);
    end
  end

  assign events.valid      = o_valid;
  assign events.key_index  = o_idx;
  assign events.is_release = o_rel;
  assign events.last_event = o_last;
endmodule
`default_nettype wire

FILE: hdl/multi_key_debounce_events.sv
// Top level: filter register, one debounce lane per key, event merging stage.
// Depends on dbk_pkg, dbk_if, dbk_lane and dbk_merge.
//
//  channel | dir | transfer carries
//  cfg     | in  | filter_ticks (8 bit)
//  keys    | in  | key_levels (13 bit), one scan tick
//  events  | out | key_index, is_release, last_event
//
// A tick is taken by all lanes at once; its events then leave at one per
// cycle through the merging stage while events is ready, and the next tick
// is taken only once the merging stage holds no more pending events.
// Reset (rst, synchronous) clears counters, states and sets filter to 10.
// A stalled events channel holds the merging stage and, through it, keys.
`default_nettype none
module multi_key_debounce_events import dbk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  dbk_cfg_if.sink   cfg,
  dbk_key_if.sink   keys,
  dbk_evt_if.source events
);
  logic [FILTER_W-1:0] filter;
  logic                tick;
  logic                idle;
  event_set_t          found;

  assign cfg.ready  = 1'b1;
  assign keys.ready = idle;
  assign tick       = keys.valid && idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter <= FILTER_RESET;
    end else if (cfg.valid) begin
      filter <= cfg.filter_ticks;
    end
  end

  assign found.up = ~keys.key_levels[NUM_KEYS-1:0];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    dbk_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .tick   (tick),
      .level  (keys.key_levels[k]),
      .filter (filter),
      .change (found.change[k])
    );
  end

  dbk_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .load   (tick),
    .found  (found),
    .idle   (idle),
    .events (events)
  );
endmodule
`default_nettype wire
